FILE: rtl/mjq_pkg.sv
`default_nettype none

package mjq_pkg;

  localparam int unsigned IN_W        = 32;
  localparam int unsigned COEF_W      = 64;
  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 392;

  // residual width (h, v*T, w*T^2) and numerator width
  localparam int unsigned XW = 100;
  localparam int unsigned NW = 104;

  // quotient bits developed by the divider; 2^QW and above saturates
  localparam int unsigned QW = 65;

  localparam int unsigned FRONT_LAT = 5;
  localparam int unsigned DIV_LAT   = QW + 4;

  // numerator pre-shift and divisor width (T^3, T^4, T^5)
  localparam int unsigned SH3 = 30;
  localparam int unsigned SH4 = 47;
  localparam int unsigned SH5 = 62;
  localparam int unsigned T3W = 96;
  localparam int unsigned T4W = 128;
  localparam int unsigned T5W = 160;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DUR = 2'd1,
    STAT_SAT      = 2'd2
  } status_t;

  // start state carried alongside the division
  typedef struct packed {
    logic signed [IN_W-1:0] p0;
    logic signed [IN_W-1:0] v0;
    logic signed [IN_W-1:0] a0;
    logic                   zero;
  } side_t;

  typedef struct packed {
    status_t                  status;
    logic signed [COEF_W-1:0] c5;
    logic signed [COEF_W-1:0] c4;
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
  } res_t;

  // signed 33 x unsigned 32
  function automatic logic signed [65:0] mul_su(input logic signed [32:0] a,
                                                input logic [31:0] b);
    logic signed [32:0] bs;
    bs = {1'b0, b};
    return a * bs;
  endfunction

  function automatic logic [63:0] mul_uu(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/min_jerk_quintic_coefficients_unit.sv
// Minimum-jerk quintic coefficients.
// Input stream (in_*): one transaction carries start and end position, velocity,
// acceleration (signed Q16.16) and the duration T (unsigned Q16.16).
// Output stream (out_*): one transaction per input with c0..c5 (signed Q32.32)
// and a status code: 0 ok, 1 T was zero (all coefficients zero), 2 one of
// c3..c5 saturated.
// Throughput: one transaction per cycle while the output buffer has room.
// Every stage is a register; c3..c5 come from three restoring dividers that
// retire one quotient bit per stage. Path from input to out_tvalid: 5 stages
// of products and residuals, 69 divider stages, 1 output buffer stage.
// Reset (rst_n low, synchronous) empties the pipeline and the output buffer;
// the datapath registers keep their contents but are marked invalid.
// Stall: a 2-entry output buffer holds finished results. While it still has
// room the pipeline keeps moving and in_tready stays high; when it is full
// the whole pipeline freezes and in_tready drops, so nothing is lost or
// repeated. in_tready does not depend combinationally on out_tready.
`default_nettype none

module min_jerk_quintic_coefficients_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
  input  wire logic [mjq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, status, zero pad
  output logic [mjq_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int unsigned LAT    = mjq_pkg::DIV_LAT;
  localparam int unsigned COEF_W = mjq_pkg::COEF_W;
  localparam int unsigned PAD_W  = mjq_pkg::OUT_TDATA_W - $bits(mjq_pkg::res_t);

  logic en;

  logic                               f_vld;
  mjq_pkg::side_t                     f_side;
  logic signed [mjq_pkg::NW-1:0]      f_n3, f_n4, f_n5;
  logic [mjq_pkg::T3W-1:0]            f_t3;
  logic [mjq_pkg::T4W-1:0]            f_t4;
  logic [mjq_pkg::T5W-1:0]            f_t5;

  logic signed [COEF_W-1:0] c3, c4, c5;
  logic                     sat3, sat4, sat5;

  // start state and valid, delayed to line up with the divider outputs
  mjq_pkg::side_t side_d_r [0:LAT-1];
  logic           vld_d_r  [0:LAT-1];

  mjq_pkg::side_t last_side;
  mjq_pkg::res_t  res;
  mjq_pkg::res_t  out_res;

  mjq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .pos0    ($signed(in_tdata[31:0])),
    .vel0    ($signed(in_tdata[63:32])),
    .acc0    ($signed(in_tdata[95:64])),
    .pos1    ($signed(in_tdata[127:96])),
    .vel1    ($signed(in_tdata[159:128])),
    .acc1    ($signed(in_tdata[191:160])),
    .dur     (in_tdata[223:192]),
    .out_vld (f_vld),
    .side    (f_side),
    .n3      (f_n3),
    .n4      (f_n4),
    .n5      (f_n5),
    .t3      (f_t3),
    .t4      (f_t4),
    .t5      (f_t5)
  );

  mjq_div #(.SH(mjq_pkg::SH3), .DW(mjq_pkg::T3W)) u_div3 (
    .clk (clk), .en (en), .n (f_n3), .d (f_t3), .coef (c3), .sat (sat3)
  );

  mjq_div #(.SH(mjq_pkg::SH4), .DW(mjq_pkg::T4W)) u_div4 (
    .clk (clk), .en (en), .n (f_n4), .d (f_t4), .coef (c4), .sat (sat4)
  );

  mjq_div #(.SH(mjq_pkg::SH5), .DW(mjq_pkg::T5W)) u_div5 (
    .clk (clk), .en (en), .n (f_n5), .d (f_t5), .coef (c5), .sat (sat5)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_d_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_d_r[0] <= f_vld;
      for (int i = 1; i < LAT; i++) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= f_side;
      for (int i = 1; i < LAT; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  // result assembly; zero duration overrides everything
  always_comb begin
    last_side = side_d_r[LAT-1];
    res       = '0;
    if (last_side.zero) begin
      res.status = mjq_pkg::STAT_ZERO_DUR;
    end else begin
      res.c0     = COEF_W'(last_side.p0) <<< 16;
      res.c1     = COEF_W'(last_side.v0) <<< 16;
      res.c2     = COEF_W'(last_side.a0) <<< 15;
      res.c3     = c3;
      res.c4     = c4;
      res.c5     = c5;
      res.status = (sat3 || sat4 || sat5) ? mjq_pkg::STAT_SAT : mjq_pkg::STAT_OK;
    end
  end

  mjq_skid u_skid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (en && vld_d_r[LAT-1]),
    .din   (res),
    .rdy   (out_tready),
    .vld   (out_tvalid),
    .dout  (out_res),
    .room  (en)
  );

  assign in_tready = en;
  assign out_tdata = {{PAD_W{1'b0}}, out_res};

endmodule

`default_nettype wire

FILE: rtl/mjq_front.sv
`default_nettype none

// Residuals, numerators and powers of T: five register stages.
module mjq_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                in_vld,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     pos0,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     vel0,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     acc0,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     pos1,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     vel1,
  input  wire logic signed [mjq_pkg::IN_W-1:0]     acc1,
  input  wire logic        [mjq_pkg::IN_W-1:0]     dur,
  output logic                                     out_vld,
  output mjq_pkg::side_t                           side,
  output logic signed [mjq_pkg::NW-1:0]            n3,
  output logic signed [mjq_pkg::NW-1:0]            n4,
  output logic signed [mjq_pkg::NW-1:0]            n5,
  output logic        [mjq_pkg::T3W-1:0]           t3,
  output logic        [mjq_pkg::T4W-1:0]           t4,
  output logic        [mjq_pkg::T5W-1:0]           t5
);

  localparam int unsigned XW  = mjq_pkg::XW;
  localparam int unsigned NW  = mjq_pkg::NW;
  localparam int unsigned T3W = mjq_pkg::T3W;
  localparam int unsigned T4W = mjq_pkg::T4W;
  localparam int unsigned T5W = mjq_pkg::T5W;

  logic [4:0] vld_r;

  // stage 1
  mjq_pkg::side_t      s1_side_r;
  logic [31:0]         s1_t_r;
  logic signed [32:0]  s1_dp_r, s1_dv_r, s1_w_r;
  logic signed [64:0]  s1_v0t_r;
  logic [63:0]         s1_t2_r;
  // stage 2
  mjq_pkg::side_t      s2_side_r;
  logic [31:0]         s2_t_r;
  logic signed [32:0]  s2_dp_r;
  logic signed [64:0]  s2_v0t_r;
  logic signed [65:0]  s2_a0lo_r, s2_a0hi_r, s2_wlo_r, s2_whi_r, s2_dvt_r;
  logic [63:0]         s2_t3lo_r, s2_t3hi_r, s2_t4ll_r, s2_t4lh_r, s2_t4hh_r;
  // stage 3
  mjq_pkg::side_t      s3_side_r;
  logic [31:0]         s3_t_r;
  logic signed [32:0]  s3_dp_r;
  logic signed [64:0]  s3_v0t_r;
  logic signed [65:0]  s3_dvt_r;
  logic signed [XW-1:0] s3_a0tt_r, s3_wtt_r;
  logic [T3W-1:0]      s3_t3_r;
  logic [T4W-1:0]      s3_t4_r;
  // stage 4
  mjq_pkg::side_t      s4_side_r;
  logic signed [XW-1:0] s4_h_r, s4_vt_r, s4_wtt_r;
  logic [T3W-1:0]      s4_t3_r;
  logic [T4W-1:0]      s4_t4_r;
  logic [63:0]         s4_t5p0_r, s4_t5p1_r, s4_t5p2_r, s4_t5p3_r;
  // stage 5
  mjq_pkg::side_t      s5_side_r;
  logic signed [NW-1:0] s5_n3_r, s5_n4_r, s5_n5_r;
  logic [T3W-1:0]      s5_t3_r;
  logic [T4W-1:0]      s5_t4_r;
  logic [T5W-1:0]      s5_t5_r;

  logic signed [NW-1:0] hx, vx, wx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_comb begin
    hx = NW'(s4_h_r);
    vx = NW'(s4_vt_r);
    wx = NW'(s4_wtt_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: differences, first products, T^2
      s1_side_r.p0   <= pos0;
      s1_side_r.v0   <= vel0;
      s1_side_r.a0   <= acc0;
      s1_side_r.zero <= (dur == '0);
      s1_t_r         <= dur;
      s1_dp_r        <= 33'(pos1) - 33'(pos0);
      s1_dv_r        <= 33'(vel1) - 33'(vel0);
      s1_w_r         <= 33'(acc1) - 33'(acc0);
      s1_v0t_r       <= 65'(mjq_pkg::mul_su(33'(vel0), dur));
      s1_t2_r        <= mjq_pkg::mul_uu(dur, dur);

      // stage 2: partial products against T^2 halves; dv*T
      s2_side_r <= s1_side_r;
      s2_t_r    <= s1_t_r;
      s2_dp_r   <= s1_dp_r;
      s2_v0t_r  <= s1_v0t_r;
      s2_a0lo_r <= mjq_pkg::mul_su(33'(s1_side_r.a0), s1_t2_r[31:0]);
      s2_a0hi_r <= mjq_pkg::mul_su(33'(s1_side_r.a0), s1_t2_r[63:32]);
      s2_wlo_r  <= mjq_pkg::mul_su(s1_w_r, s1_t2_r[31:0]);
      s2_whi_r  <= mjq_pkg::mul_su(s1_w_r, s1_t2_r[63:32]);
      s2_dvt_r  <= mjq_pkg::mul_su(s1_dv_r, s1_t_r);
      s2_t3lo_r <= mjq_pkg::mul_uu(s1_t2_r[31:0], s1_t_r);
      s2_t3hi_r <= mjq_pkg::mul_uu(s1_t2_r[63:32], s1_t_r);
      s2_t4ll_r <= mjq_pkg::mul_uu(s1_t2_r[31:0], s1_t2_r[31:0]);
      s2_t4lh_r <= mjq_pkg::mul_uu(s1_t2_r[31:0], s1_t2_r[63:32]);
      s2_t4hh_r <= mjq_pkg::mul_uu(s1_t2_r[63:32], s1_t2_r[63:32]);

      // stage 3: partial sums
      s3_side_r <= s2_side_r;
      s3_t_r    <= s2_t_r;
      s3_dp_r   <= s2_dp_r;
      s3_v0t_r  <= s2_v0t_r;
      s3_dvt_r  <= s2_dvt_r;
      s3_a0tt_r <= XW'(s2_a0lo_r) + (XW'(s2_a0hi_r) <<< 32);
      s3_wtt_r  <= XW'(s2_wlo_r) + (XW'(s2_whi_r) <<< 32);
      s3_t3_r   <= T3W'(s2_t3lo_r) + (T3W'(s2_t3hi_r) << 32);
      s3_t4_r   <= T4W'(s2_t4ll_r) + (T4W'(s2_t4lh_r) << 33) + (T4W'(s2_t4hh_r) << 64);

      // stage 4: residuals h, v*T, w*T^2; T^5 partials
      s4_side_r <= s3_side_r;
      s4_h_r    <= (XW'(s3_dp_r) <<< 33) - (XW'(s3_v0t_r) <<< 17) - s3_a0tt_r;
      s4_vt_r   <= (XW'(s3_dvt_r) <<< 16) - s3_a0tt_r;
      s4_wtt_r  <= s3_wtt_r;
      s4_t3_r   <= s3_t3_r;
      s4_t4_r   <= s3_t4_r;
      s4_t5p0_r <= mjq_pkg::mul_uu(s3_t4_r[31:0], s3_t_r);
      s4_t5p1_r <= mjq_pkg::mul_uu(s3_t4_r[63:32], s3_t_r);
      s4_t5p2_r <= mjq_pkg::mul_uu(s3_t4_r[95:64], s3_t_r);
      s4_t5p3_r <= mjq_pkg::mul_uu(s3_t4_r[127:96], s3_t_r);

      // stage 5: numerators as shift-add
      s5_side_r <= s4_side_r;
      // 20h - 16vT + 2wT^2
      s5_n3_r <= (hx <<< 4) + (hx <<< 2) - (vx <<< 4) + (wx <<< 1);
      // 14vT - 15h - 2wT^2
      s5_n4_r <= (vx <<< 4) - (vx <<< 1) - (hx <<< 4) + hx - (wx <<< 1);
      // 12h - 12vT + 2wT^2
      s5_n5_r <= (hx <<< 3) + (hx <<< 2) - (vx <<< 3) - (vx <<< 2) + (wx <<< 1);
      s5_t3_r <= s4_t3_r;
      s5_t4_r <= s4_t4_r;
      s5_t5_r <= T5W'(s4_t5p0_r) + (T5W'(s4_t5p1_r) << 32) + (T5W'(s4_t5p2_r) << 64)
               + (T5W'(s4_t5p3_r) << 96);
    end
  end

  assign out_vld = vld_r[4];
  assign side    = s5_side_r;
  assign n3      = s5_n3_r;
  assign n4      = s5_n4_r;
  assign n5      = s5_n5_r;
  assign t3      = s5_t3_r;
  assign t4      = s5_t4_r;
  assign t5      = s5_t5_r;

endmodule

`default_nettype wire

FILE: rtl/mjq_div.sv
`default_nettype none

// Pipelined restoring divider: round(|n| * 2^SH / d), signed, saturated to Q32.32.
// One quotient bit per stage.
module mjq_div #(
  parameter int unsigned SH = mjq_pkg::SH3,
  parameter int unsigned DW = mjq_pkg::T3W
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [mjq_pkg::NW-1:0]      n,
  input  wire logic        [DW-1:0]               d,
  output logic signed [mjq_pkg::COEF_W-1:0]       coef,
  output logic                                    sat
);

  localparam int unsigned NW  = mjq_pkg::NW;
  localparam int unsigned QW  = mjq_pkg::QW;
  localparam int unsigned CW_ = mjq_pkg::COEF_W;
  localparam int unsigned MW  = NW + SH;
  localparam int unsigned HIW = MW - QW;
  localparam int unsigned CMW = (HIW > DW) ? HIW : DW;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned QRW = QW + 1;

  localparam logic [QRW-1:0] POS_MAX = QRW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [QRW-1:0] NEG_MAX = QRW'(64'h8000_0000_0000_0000);
  localparam logic [CW_-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CW_-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // prep stage
  logic [NW-1:0] mag_p_r;
  logic          neg_p_r;
  logic [DW-1:0] d_p_r;

  // bit stages
  logic [DW-1:0] rem_r [0:QW];
  logic [DW-1:0] dv_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic [QW-1:0] lo_r  [0:QW-1];
  logic          neg_r [0:QW];
  logic          ovf_r [0:QW];

  // rounding and saturation stages
  logic [QRW-1:0] qr_r;
  logic           neg_f_r, ovf_f_r;
  logic [CW_-1:0] coef_r;
  logic           sat_r;

  logic [MW-1:0]  m_w;
  logic [HIW-1:0] hi_w;
  logic           rnd_w;
  logic           sat_w;

  always_comb begin
    m_w   = {mag_p_r, {SH{1'b0}}};
    hi_w  = m_w[MW-1:QW];
    rnd_w = ({rem_r[QW], 1'b0} >= {1'b0, dv_r[QW]});
    if (neg_f_r) begin
      sat_w = ovf_f_r || (qr_r > NEG_MAX);
    end else begin
      sat_w = ovf_f_r || (qr_r > POS_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_p_r <= n[NW-1] ? NW'(-n) : NW'(n);
      neg_p_r <= n[NW-1];
      d_p_r   <= d;

      rem_r[0] <= DW'(hi_w);
      lo_r[0]  <= m_w[QW-1:0];
      q_r[0]   <= '0;
      dv_r[0]  <= d_p_r;
      neg_r[0] <= neg_p_r;
      ovf_r[0] <= (CMW'(hi_w) >= CMW'(d_p_r));

      qr_r    <= {1'b0, q_r[QW]} + QRW'(rnd_w);
      neg_f_r <= neg_r[QW];
      ovf_f_r <= ovf_r[QW];

      sat_r <= sat_w;
      if (sat_w) begin
        coef_r <= neg_f_r ? SAT_NEG : SAT_POS;
      end else begin
        coef_r <= neg_f_r ? (~qr_r[CW_-1:0] + CW_'(1)) : qr_r[CW_-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [RW-1:0] sh_w;
    logic [RW-1:0] diff_w;
    logic          ge_w;

    always_comb begin
      sh_w   = {rem_r[k-1], lo_r[k-1][QW-1]};
      diff_w = sh_w - {1'b0, dv_r[k-1]};
      ge_w   = (sh_w >= {1'b0, dv_r[k-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge_w ? diff_w[DW-1:0] : sh_w[DW-1:0];
        q_r[k]   <= {q_r[k-1][QW-2:0], ge_w};
        dv_r[k]  <= dv_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QW) begin : g_lo
      always_ff @(posedge clk) begin
        if (en) begin
          lo_r[k] <= {lo_r[k-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign coef = coef_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

FILE: rtl/mjq_skid.sv
`default_nettype none

// Two-entry output buffer; room depends on registered state only.
module mjq_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mjq_pkg::res_t   din,
  input  wire logic            rdy,
  output logic                 vld,
  output mjq_pkg::res_t        dout,
  output logic                 room
);

  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_FULL  = 2'd2;

  logic [1:0]    count_r, count_nxt;
  mjq_pkg::res_t head_r, tail_r;
  logic          pop;

  always_comb begin
    pop       = (count_r != CNT_EMPTY) && rdy;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_EMPTY;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == CNT_FULL) begin
        head_r <= tail_r;
        if (push) begin
          tail_r <= din;
        end
      end else if (push) begin
        head_r <= din;
      end
    end else if (push) begin
      if (count_r == CNT_EMPTY) begin
        head_r <= din;
      end else begin
        tail_r <= din;
      end
    end
  end

  assign vld  = (count_r != CNT_EMPTY);
  assign dout = head_r;
  assign room = (count_r != CNT_FULL);

endmodule

`default_nettype wire

FILE: tb/mjq_scoreboard.sv
`timescale 1ns / 1ps

module mjq_scoreboard (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [mjq_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [mjq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                  fail_count,
  output int                                  pending
);

  mjq_pkg::res_t coef_queue[$];

  // rounded, saturated Q32.32 value of n * 2^sh / t^pw
  function automatic logic [63:0] div_q32(input logic signed [255:0] n, input int sh,
                                          input int pw, input logic [255:0] t,
                                          inout bit sat);
    logic [255:0] mag, dvs, quo, rem;
    bit neg;
    neg = n < 0;
    mag = neg ? -n : n;
    mag = mag << sh;
    dvs = 256'd1;
    for (int i = 0; i < pw; i++) dvs = dvs * t;
    quo = mag / dvs;
    rem = mag % dvs;
    if ((rem << 1) >= dvs) quo = quo + 1;
    if (!neg) begin
      if (quo > 256'h7FFF_FFFF_FFFF_FFFF) begin
        sat = 1;
        return 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return quo[63:0];
    end
    if (quo > 256'h8000_0000_0000_0000) begin
      sat = 1;
      return 64'h8000_0000_0000_0000;
    end
    return -quo[63:0];
  endfunction

  function automatic mjq_pkg::res_t predict_coefs(input logic [mjq_pkg::IN_TDATA_W-1:0] d);
    logic signed [255:0] p0, v0, a0, pt, vt, at, t, h, v, w, vtt, wtt, n3, n4, n5;
    mjq_pkg::res_t r;
    bit sat;
    sat = 0;
    r = '0;
    p0 = $signed(d[31:0]);
    v0 = $signed(d[63:32]);
    a0 = $signed(d[95:64]);
    pt = $signed(d[127:96]);
    vt = $signed(d[159:128]);
    at = $signed(d[191:160]);
    t  = {224'd0, d[223:192]};
    if (t == 0) begin
      r.status = mjq_pkg::STAT_ZERO_DUR;
      return r;
    end
    r.c0 = p0[63:0] << 16;
    r.c1 = v0[63:0] << 16;
    r.c2 = a0[63:0] << 15;
    // h scaled by 2^49, v by 2^32, w by 2^16
    h = ((pt - p0) <<< 33) - ((v0 * t) <<< 17) - a0 * t * t;
    v = ((vt - v0) <<< 16) - a0 * t;
    w = at - a0;
    vtt = v * t;
    wtt = w * t * t;
    n3 = 20 * h - 16 * vtt + 2 * wtt;
    n4 = 14 * vtt - 15 * h - 2 * wtt;
    n5 = 12 * h - 12 * vtt + 2 * wtt;
    r.c3 = div_q32(n3, mjq_pkg::SH3, 3, t, sat);
    r.c4 = div_q32(n4, mjq_pkg::SH4, 4, t, sat);
    r.c5 = div_q32(n5, mjq_pkg::SH5, 5, t, sat);
    r.status = sat ? mjq_pkg::STAT_SAT : mjq_pkg::STAT_OK;
    return r;
  endfunction

  assign pending = coef_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    mjq_pkg::res_t got, want;
    logic [63:0] gc[6], wc[6];
    if (rst_n && in_tvalid && in_tready) coef_queue = {coef_queue, predict_coefs(in_tdata)};
    if (rst_n && out_tvalid && out_tready) begin
      got = mjq_pkg::res_t'(out_tdata[$bits(mjq_pkg::res_t)-1:0]);
      if (coef_queue.size() == 0) begin
        $error("unexpected output transaction %h", out_tdata);
        fail_count++;
      end else begin
        want = coef_queue.pop_front();
        gc = '{got.c0, got.c1, got.c2, got.c3, got.c4, got.c5};
        wc = '{want.c0, want.c1, want.c2, want.c3, want.c4, want.c5};
        for (int i = 0; i < 6; i++)
          if (gc[i] !== wc[i]) begin
            $error("coef_%0d: expected %h, got %h", i, wc[i], gc[i]);
            fail_count++;
          end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_RANDOM = 1730;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [mjq_pkg::IN_TDATA_W-1:0]   in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [mjq_pkg::OUT_TDATA_W-1:0]  out_tdata;
  int                               fail_count;
  int                               pending;
  bit                               hold_off_req;

  min_jerk_quintic_coefficients_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mjq_scoreboard u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // tdata layout: start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
  // duration, 32 bits each from bit 0 up
  function automatic logic [mjq_pkg::IN_TDATA_W-1:0] pack_request(input logic [31:0] p0, v0,
                                                                  a0, pt, vt, at, dur);
    return {dur, at, vt, pt, a0, v0, p0};
  endfunction

  // signed value with a random magnitude scale, so small physical values dominate
  function automatic logic [31:0] scaled_rand();
    return $signed($urandom) >>> $urandom_range(4, 31);
  endfunction

  function automatic logic [mjq_pkg::IN_TDATA_W-1:0] random_request();
    logic [31:0] dur;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // raw noise over the whole field range
      dur = (kind < 2) ? 32'd0 : $urandom;
      return pack_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, dur);
    end
    // plausible motion: duration mostly 0.06 s .. 40 s, mostly non-saturating
    dur = $urandom_range(32'h0000_1000, 32'h0028_0000);
    if (kind < 30) dur = $urandom_range(1, 32'h0000_0100);
    return pack_request(scaled_rand(), scaled_rand(), scaled_rand(),
                        scaled_rand(), scaled_rand(), scaled_rand(), dur);
  endfunction

  // one transaction; gap cycles of in_tvalid low first
  task automatic send_request(input logic [mjq_pkg::IN_TDATA_W-1:0] req, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver: random back-pressure, burst stretches, and one long hold-off
  initial begin
    int wait_cycles;
    bit burst;
    out_tready = 1'b0;
    burst = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        repeat (400) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      if ($urandom_range(0, 63) == 0) burst = !burst;
      wait_cycles = burst ? 0 : $urandom_range(0, 5);
      repeat (wait_cycles) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] mx, mn;
    bit burst;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    hold_off_req = 0;
    burst        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero duration, tiny and huge durations, field extremes
    send_request(pack_request(32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'd0), 0);
    send_request(pack_request(mx, mx, mx, mx, mx, mx, 32'd0), 0);
    send_request(pack_request('0, '0, '0, '0, '0, '0, 32'h0001_0000), 0);
    send_request(pack_request('0, '0, '0, 32'h0001_0000, '0, '0, 32'h0001_0000), 1);
    send_request(pack_request('0, '0, '0, 32'h0001_0000, '0, '0, 32'd1), 0);
    send_request(pack_request(mx, mx, mx, mx, mx, mx, 32'hFFFF_FFFF), 0);
    send_request(pack_request(mn, mn, mn, mn, mn, mn, 32'hFFFF_FFFF), 2);
    send_request(pack_request(mn, mx, mn, mx, mn, mx, 32'hFFFF_FFFF), 0);
    send_request(pack_request(mx, mn, mx, mn, mx, mn, 32'hFFFF_FFFF), 0);
    send_request(pack_request(mn, mx, mn, mx, mn, mx, 32'd1), 0);
    send_request(pack_request(mx, mn, mx, mn, mx, mn, 32'd1), 3);
    send_request(pack_request(mn, '0, '0, mx, '0, '0, 32'h0001_0000), 0);
    send_request(pack_request(mx, '0, '0, mn, '0, '0, 32'h0001_0000), 0);
    send_request(pack_request('0, mx, '0, '0, mn, '0, 32'h0002_0000), 0);
    send_request(pack_request('0, '0, mn, '0, '0, mx, 32'h0000_8000), 0);
    send_request(pack_request('1, '1, '1, '1, '1, '1, 32'h8000_0000), 0);
    send_request(pack_request(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                              32'h000A_0000, '0, '0, 32'h0003_0000), 0);
    send_request(pack_request(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0000_0003), 1);
    send_request(pack_request('0, '0, '0, '0, '0, '0, 32'd0), 0);

    // random: plausible trajectories with noise mixed in
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == 600) hold_off_req = 1;  // receiver stalls, sender keeps pushing
      send_request(random_request(), (burst || i >= 600 && i < 700) ? 0 : $urandom_range(0, 5));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("min_jerk_quintic_coefficients_unit test passed");
    end else begin
      $display("min_jerk_quintic_coefficients_unit test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("min_jerk_quintic_coefficients_unit test failed");
    $finish;
  end

endmodule
